@@ rtl/core/hbct_pkg.sv @@
`default_nettype none

package hbct_pkg;

  typedef enum logic [1:0] {
    ACT_GET     = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_PIN     = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFREE = 2'd1,
    ST_UNDER  = 2'd2,
    ST_OVER   = 2'd3
  } status_e;

  localparam logic [31:0] HashMul   = 32'h045d9f3b;
  localparam int          HashShift = 16;
  localparam logic [7:0]  RefMax    = 8'hFF;
  localparam int          Nibbles   = 8;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_HASH1 = 10'b0000000010,
    S_HASH2 = 10'b0000000100,
    S_HASH3 = 10'b0000001000,
    S_MOD   = 10'b0000010000,
    S_SETUP = 10'b0000100000,
    S_SRCH  = 10'b0001000000,
    S_ALLOC = 10'b0010000000,
    S_SLOT  = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } state_e;

  typedef struct packed {
    logic load;
    logic hash1;
    logic hash2;
    logic hash3;
    logic mod_step;
    logic setup;
    logic srch;
    logic alloc;
    logic slot_op;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic mod_last;
    logic match;
    logic free;
    logic wrap;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/core/hbct_ctrl.sv @@
`default_nettype none

module hbct_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [1:0]       action_i,
  input  hbct_pkg::sts_t   sts_i,
  output hbct_pkg::cmd_t   cmd_o,
  output logic             in_stall_o
);

  hbct_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hbct_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_stall_o = (state_q != hbct_pkg::S_IDLE);
    case (state_q)
      hbct_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          case (hbct_pkg::action_e'(action_i))
            hbct_pkg::ACT_GET:     state_d = hbct_pkg::S_HASH1;
            hbct_pkg::ACT_RELEASE: state_d = hbct_pkg::S_SLOT;
            hbct_pkg::ACT_PIN:     state_d = hbct_pkg::S_SLOT;
            default:               state_d = hbct_pkg::S_FIN;
          endcase
        end
      end
      hbct_pkg::S_HASH1: begin
        cmd_o.hash1 = 1'b1;
        state_d     = hbct_pkg::S_HASH2;
      end
      hbct_pkg::S_HASH2: begin
        cmd_o.hash2 = 1'b1;
        state_d     = hbct_pkg::S_HASH3;
      end
      hbct_pkg::S_HASH3: begin
        cmd_o.hash3 = 1'b1;
        state_d     = hbct_pkg::S_MOD;
      end
      hbct_pkg::S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_last) state_d = hbct_pkg::S_SETUP;
      end
      hbct_pkg::S_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = hbct_pkg::S_SRCH;
      end
      hbct_pkg::S_SRCH: begin
        cmd_o.srch = 1'b1;
        if (sts_i.match) begin
          state_d = hbct_pkg::S_FIN;
        end else if (sts_i.wrap) begin
          state_d = hbct_pkg::S_ALLOC;
        end
      end
      hbct_pkg::S_ALLOC: begin
        cmd_o.alloc = 1'b1;
        if (sts_i.free || sts_i.wrap) state_d = hbct_pkg::S_FIN;
      end
      hbct_pkg::S_SLOT: begin
        cmd_o.slot_op = 1'b1;
        state_d       = hbct_pkg::S_FIN;
      end
      hbct_pkg::S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = hbct_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = hbct_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/hbct_dp.sv @@
`default_nettype none

module hbct_dp #(
  parameter int BUCKETS      = 8,
  parameter int WAYS         = 4,
  parameter int ENTRIES_USED = 30
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  hbct_pkg::cmd_t  cmd_i,
  input  logic [1:0]      action_i,
  input  logic [31:0]     device_i,
  input  logic [31:0]     block_number_i,
  input  logic [4:0]      slot_i,
  input  logic            out_stall_i,
  output hbct_pkg::sts_t  sts_o,
  output logic            out_valid_o,
  output logic [4:0]      entry_o,
  output logic            hit_o,
  output logic            needs_read_o,
  output logic [1:0]      status_o
);

  localparam int Total = BUCKETS * WAYS;
  localparam int IW    = $clog2(Total);
  localparam int BW    = $clog2(BUCKETS);
  localparam int RW    = BW + 1;
  localparam int Limit = (Total > ENTRIES_USED) ? (Total - ENTRIES_USED) : 0;

  function automatic logic enabled(input int b, input int w);
    return !((b < Limit) && (w == WAYS - 1));
  endfunction

  function automatic logic [31:0] fold(input logic [31:0] x);
    return (x >> hbct_pkg::HashShift) ^ x;
  endfunction

  logic [1:0]    act_q;
  logic [31:0]   dev_q, blk_q;
  logic [4:0]    slot_q;
  logic [31:0]   x_q;
  logic [BW-1:0] rem_q, rem_d;
  logic [2:0]    ncnt_q;
  logic [BW-1:0] home_q, cur_q, cur_next, rd_b;
  logic [BW-1:0] home_next;

  logic [7:0]    ref_q [Total];
  logic          dv_q  [Total];
  logic          wr_q  [Total];

  logic [63:0]   tag_mem [WAYS][BUCKETS];
  logic [63:0]   rdata_q [WAYS];

  logic [4:0]    res_entry_q;
  logic          res_hit_q, res_nread_q;
  logic [1:0]    res_status_q;
  logic          out_valid_q;
  logic [4:0]    out_entry_q;
  logic          out_hit_q, out_nread_q;
  logic [1:0]    out_status_q;

  logic          match, free;
  logic [IW-1:0] m_idx, f_idx;
  int            f_way;
  logic          s_ok;
  logic [IW-1:0] s_idx;

  assign cur_next  = (cur_q == BW'(BUCKETS - 1)) ? '0 : cur_q + 1'b1;
  assign home_next = (home_q == BW'(BUCKETS - 1)) ? '0 : home_q + 1'b1;
  assign rd_b      = cmd_i.srch ? cur_next : cur_q;

  // Four bits of the hash enter the remainder per cycle.
  always_comb begin
    logic [RW-1:0] r;
    r = {1'b0, rem_q};
    for (int k = 0; k < 4; k++) begin
      r = {r[RW-2:0], x_q[31-k]};
      if (r >= RW'(BUCKETS)) r = r - RW'(BUCKETS);
    end
    rem_d = r[BW-1:0];
  end

  // Search one bucket: first matching way and first free way.
  always_comb begin
    logic [IW-1:0] idx;
    logic [63:0]   tag;
    match = 1'b0;
    free  = 1'b0;
    m_idx = '0;
    f_idx = '0;
    f_way = 0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      idx = IW'(int'(cur_q) * WAYS + w);
      tag = wr_q[idx] ? rdata_q[w] : 64'd0;
      if (enabled(int'(cur_q), w) && (tag == {dev_q, blk_q})) begin
        match = 1'b1;
        m_idx = idx;
      end
      if (enabled(int'(cur_q), w) && (ref_q[idx] == 8'd0)) begin
        free  = 1'b1;
        f_idx = idx;
        f_way = w;
      end
    end
  end

  always_comb begin
    s_ok  = (32'(slot_q) < 32'(Total));
    s_idx = IW'(slot_q);
    for (int b = 0; b < BUCKETS; b++) begin
      if (!enabled(b, WAYS - 1) && (32'(slot_q) == 32'(b * WAYS + WAYS - 1))) s_ok = 1'b0;
    end
  end

  assign sts_o.mod_last = cmd_i.mod_step && (ncnt_q == 3'(hbct_pkg::Nibbles - 1));
  assign sts_o.match    = match;
  assign sts_o.free     = free;
  assign sts_o.wrap     = (cur_next == home_q);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q  <= action_i;
      dev_q  <= device_i;
      blk_q  <= block_number_i;
      slot_q <= slot_i;
    end
    if (cmd_i.hash1) x_q <= fold(blk_q) * hbct_pkg::HashMul;
    if (cmd_i.hash2) x_q <= fold(x_q) * hbct_pkg::HashMul;
    if (cmd_i.hash3) begin
      x_q    <= fold(x_q);
      rem_q  <= '0;
      ncnt_q <= '0;
    end
    if (cmd_i.mod_step) begin
      x_q    <= x_q << 4;
      rem_q  <= rem_d;
      ncnt_q <= ncnt_q + 3'd1;
      if (sts_o.mod_last) begin
        home_q <= rem_d;
        cur_q  <= rem_d;
      end
    end
    // The allocation sweep starts one bucket past home.
    if (cmd_i.srch && !match) cur_q <= sts_o.wrap ? home_next : cur_next;
    if (cmd_i.alloc && !free) cur_q <= cur_next;
  end

  for (genvar g = 0; g < WAYS; g++) begin : g_way
    always_ff @(posedge clk_i) begin
      if (cmd_i.alloc && free && (f_way == g)) tag_mem[g][cur_q] <= {dev_q, blk_q};
      rdata_q[g] <= tag_mem[g][rd_b];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Total; i++) begin
        ref_q[i] <= 8'd0;
        dv_q[i]  <= 1'b0;
        wr_q[i]  <= 1'b0;
      end
    end else begin
      if (cmd_i.srch && match) begin
        if (ref_q[m_idx] != hbct_pkg::RefMax) ref_q[m_idx] <= ref_q[m_idx] + 8'd1;
        dv_q[m_idx] <= 1'b1;
      end
      if (cmd_i.alloc && free) begin
        ref_q[f_idx] <= 8'd1;
        dv_q[f_idx]  <= 1'b1;
        wr_q[f_idx]  <= 1'b1;
      end
      if (cmd_i.slot_op && s_ok) begin
        if (act_q == hbct_pkg::ACT_RELEASE) begin
          if (ref_q[s_idx] != 8'd0) ref_q[s_idx] <= ref_q[s_idx] - 8'd1;
        end else begin
          if (ref_q[s_idx] != hbct_pkg::RefMax) ref_q[s_idx] <= ref_q[s_idx] + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_entry_q  <= slot_i;
      res_hit_q    <= 1'b0;
      res_nread_q  <= 1'b0;
      res_status_q <= hbct_pkg::ST_OK;
    end
    if (cmd_i.srch && match) begin
      res_entry_q  <= 5'(m_idx);
      res_hit_q    <= 1'b1;
      res_nread_q  <= !dv_q[m_idx];
      res_status_q <= (ref_q[m_idx] == hbct_pkg::RefMax) ? hbct_pkg::ST_OVER : hbct_pkg::ST_OK;
    end
    if (cmd_i.alloc && free) begin
      res_entry_q <= 5'(f_idx);
      res_nread_q <= 1'b1;
    end
    if (cmd_i.alloc && !free && sts_o.wrap) begin
      res_entry_q  <= 5'd0;
      res_status_q <= hbct_pkg::ST_NOFREE;
    end
    if (cmd_i.slot_op && s_ok) begin
      if (act_q == hbct_pkg::ACT_RELEASE) begin
        if (ref_q[s_idx] == 8'd0) res_status_q <= hbct_pkg::ST_UNDER;
      end else begin
        if (ref_q[s_idx] == hbct_pkg::RefMax) res_status_q <= hbct_pkg::ST_OVER;
      end
    end
    if (cmd_i.emit) begin
      out_entry_q  <= res_entry_q;
      out_hit_q    <= res_hit_q;
      out_nread_q  <= res_nread_q;
      out_status_q <= res_status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign entry_o      = out_entry_q;
  assign hit_o        = out_hit_q;
  assign needs_read_o = out_nread_q;
  assign status_o     = out_status_q;

  a_nofree_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == hbct_pkg::ST_NOFREE) |-> (out_entry_q == 5'd0 && !out_hit_q
      && !out_nread_q))
    else $error("no-free result carries a grant");

  a_hit_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_hit_q) |-> (out_status_q == hbct_pkg::ST_OK
      || out_status_q == hbct_pkg::ST_OVER))
    else $error("hit with bad status");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> !(out_valid_q && out_stall_i))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

@@ rtl/core/hashed_buffer_cache_tags.sv @@
// Sequence: a get runs the multiply states S_HASH1, S_HASH2, the fold S_HASH3, then S_MOD
//   (4 bits a step), read setup, a search of up to BUCKETS buckets, an allocation sweep of
//   up to BUCKETS-1, then S_FIN; release and pin pass S_SLOT, the unused action only S_FIN.
// Throughput: one item at a time, the next taken once a result leaves; a get is bound by
//   one tag row read per cycle from the way memories; output stalls add to all actions.
// Reset: asynchronous, active low; clears the controller, reference counts and valid bits.
`default_nettype none

module hashed_buffer_cache_tags #(
  parameter int BUCKETS      = 8,
  parameter int WAYS         = 4,
  parameter int ENTRIES_USED = 30
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [31:0] device_i,
  input  logic [31:0] block_number_i,
  input  logic [4:0]  slot_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  entry_o,
  output logic        hit_o,
  output logic        needs_read_o,
  output logic [1:0]  status_o
);

  // The controller sequences a get through hashing, the bucket search starting at the home
  // bucket, and the allocation sweep that starts one bucket past home; release and pin use S_SLOT.
  // The datapath holds the tag memories (one per way, one row per bucket), the
  // reference counts and the result register that parts the output side.
  hbct_pkg::cmd_t cmd;
  hbct_pkg::sts_t sts;

  hbct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  hbct_dp #(
    .BUCKETS      (BUCKETS),
    .WAYS         (WAYS),
    .ENTRIES_USED (ENTRIES_USED)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .action_i       (action_i),
    .device_i       (device_i),
    .block_number_i (block_number_i),
    .slot_i         (slot_i),
    .out_stall_i    (out_stall_i),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .entry_o        (entry_o),
    .hit_o          (hit_o),
    .needs_read_o   (needs_read_o),
    .status_o       (status_o)
  );

endmodule

`default_nettype wire
